/* rtl/core/assert_macros.svh */
// Assertion helpers used by the core RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define DNAKM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DNAKM_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define DNAKM_ASSERT(lbl, clk, rst, prop, msg)
`define DNAKM_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* rtl/core/dnakm_pkg.sv */
package dnakm_pkg;

  // Item opcodes, also used as command kinds in the queue
  localparam logic [2:0] OP_LOAD_GOTO  = 3'd0;
  localparam logic [2:0] OP_LOAD_FAIL  = 3'd1;
  localparam logic [2:0] OP_LOAD_LIST  = 3'd2;
  localparam logic [2:0] OP_BASE       = 3'd3;
  localparam logic [2:0] OP_READ_START = 3'd4;

  // Symbol codes
  localparam logic [2:0] SYM_A     = 3'd0;
  localparam logic [2:0] SYM_C     = 3'd1;
  localparam logic [2:0] SYM_G     = 3'd2;
  localparam logic [2:0] SYM_T     = 3'd3;
  localparam logic [2:0] SYM_OTHER = 3'd4;

  // Base characters
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  // Command queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] index;
    logic [2:0]  sym;
    logic [15:0] target;
    logic        tvalid;
    logic [15:0] start;
    logic [3:0]  count;
  } cmd_t;

  function automatic logic [2:0] base_symbol(input logic [7:0] b);
    logic [2:0] s;
    unique case (b)
      CHAR_A:  s = SYM_A;
      CHAR_C:  s = SYM_C;
      CHAR_G:  s = SYM_G;
      CHAR_T:  s = SYM_T;
      default: s = SYM_OTHER;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/dna_multi_keyword_matcher_core.sv */
// Aho-Corasick keyword matcher over DNA bases.
// Input channel (item_valid/item_ready) carries one transaction per item:
// table loads (goto, failure plus output descriptor, keyword list entry),
// bases and read-start markers. Loads and read-starts give no result.
// Each base gives one or more results on result_valid/result_ready:
// one per keyword group in the new state's output set, or one no-match
// result; the final one carries last.
// A front stage classifies items and queues them (four entries); a back
// sequencer walks failure links in the goto and failure memories, then
// streams the keyword list. A base reads the goto memory, each failure step
// reads the failure then the goto memory, then the descriptor is read;
// matches follow one per cycle while the receiver takes them. The back takes
// no new command until a base's last result is loaded, but a load every cycle.
// A failure/descriptor load holds the front while its list start is reduced
// (multiply, then subtract) when the list is under 65536 deep.
// Reset returns the automaton to the root; tables are unknown until loaded.
// When the receiver stalls, the result register holds and the queue fills,
// then item_ready drops.
module dna_multi_keyword_matcher_core import dnakm_pkg::*; #(
  parameter int NUM_STATES  = 65536,
  parameter int LIST_DEPTH  = 65536,
  parameter int MAX_OUTPUTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  op,
  input  logic [15:0] state_index,
  input  logic [2:0]  symbol,
  input  logic [15:0] target_state,
  input  logic        target_valid,
  input  logic [15:0] out_start,
  input  logic [3:0]  out_count,
  input  logic [15:0] list_index,
  input  logic [15:0] group_id,
  input  logic [7:0]  base,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        matched,
  output logic [15:0] match_group,
  output logic [15:0] state_after,
  output logic        last
);

  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  dnakm_front #(
    .NUM_STATES(NUM_STATES), .LIST_DEPTH(LIST_DEPTH), .MAX_OUTPUTS(MAX_OUTPUTS)
  ) u_front (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready),
    .op(op), .state_index(state_index), .symbol(symbol),
    .target_state(target_state), .target_valid(target_valid),
    .out_start(out_start), .out_count(out_count), .list_index(list_index),
    .group_id(group_id), .base(base),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  dnakm_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
    .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
  );

  dnakm_back #(.NUM_STATES(NUM_STATES), .LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .result_valid(result_valid), .result_ready(result_ready),
    .matched(matched), .match_group(match_group),
    .state_after(state_after), .last(last)
  );

endmodule

/* rtl/core/dnakm_ram.sv */
module dnakm_ram import dnakm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read data registered and held between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/dnakm_front.sv */
module dnakm_front import dnakm_pkg::*; #(
  parameter int NUM_STATES  = 65536,
  parameter int LIST_DEPTH  = 65536,
  parameter int MAX_OUTPUTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  op,
  input  logic [15:0] state_index,
  input  logic [2:0]  symbol,
  input  logic [15:0] target_state,
  input  logic        target_valid,
  input  logic [15:0] out_start,
  input  logic [3:0]  out_count,
  input  logic [15:0] list_index,
  input  logic [15:0] group_id,
  input  logic [7:0]  base,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  // Start reduction: quotient by reciprocal multiply, exact for 16-bit starts
  localparam bit          LIST_SHORT = LIST_DEPTH < 65536;
  localparam logic [16:0] LIST_MOD   = 17'(LIST_SHORT ? LIST_DEPTH : 0);
  localparam logic [32:0] LIST_RECIP =
    33'(LIST_SHORT ? (((64'd1 << 32) + 64'(LIST_DEPTH) - 64'd1) / 64'(LIST_DEPTH)) : 64'd0);

  logic       hold_valid;
  cmd_t       hold;
  logic [1:0] red_cnt;
  logic       push;
  logic       accept;
  logic       keep;
  cmd_t       dcmd;
  logic [47:0] red_prod;
  logic [15:0] red_quot;
  logic [15:0] red_next;
  logic        si_ok;

  // Hand the held command on once its list start is reduced
  assign push       = hold_valid && (red_cnt == 2'd0) && cmd_ready;
  assign item_ready = !hold_valid || push;
  assign accept     = item_valid && item_ready;
  assign cmd_valid  = hold_valid && (red_cnt == 2'd0);
  assign cmd        = hold;

  // Classify the item and drop loads that fall outside the tables and unknown opcodes
  assign si_ok = 32'(state_index) < NUM_STATES;
  always_comb begin
    unique case (op)
      OP_LOAD_GOTO:  keep = si_ok && (symbol <= SYM_OTHER);
      OP_LOAD_FAIL:  keep = si_ok;
      OP_LOAD_LIST:  keep = 32'(list_index) < LIST_DEPTH;
      OP_BASE:       keep = 1'b1;
      OP_READ_START: keep = 1'b1;
      default:       keep = 1'b0;
    endcase
    dcmd.op     = op;
    dcmd.index  = (op == OP_LOAD_LIST) ? list_index : state_index;
    dcmd.sym    = (op == OP_BASE) ? base_symbol(base) : symbol;
    dcmd.target = (op == OP_LOAD_LIST) ? group_id : target_state;
    dcmd.tvalid = target_valid;
    dcmd.start  = out_start;
    dcmd.count  = (7'(out_count) > 7'(MAX_OUTPUTS)) ? 4'(MAX_OUTPUTS) : out_count;
  end

  // Remainder of start by the list depth: start minus quotient times depth
  assign red_quot = red_prod[47:32];
  assign red_next = hold.start - 16'(32'(red_quot) * 32'(LIST_MOD));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      red_cnt    <= 2'd0;
    end else if (accept) begin
      hold_valid <= keep;
      red_cnt    <= (keep && (op == OP_LOAD_FAIL) && LIST_SHORT) ? 2'd2 : 2'd0;
    end else if (push) begin
      hold_valid <= 1'b0;
    end else if (red_cnt != 2'd0) begin
      red_cnt <= red_cnt - 2'd1;
    end
  end

  // Payload: capture on accept, then multiply and subtract in place
  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= dcmd;
    end else if (red_cnt == 2'd2) begin
      red_prod <= 48'(hold.start) * 48'(LIST_RECIP);
    end else if (red_cnt == 2'd1) begin
      hold.start <= red_next;
    end
  end

endmodule

/* rtl/core/dnakm_queue.sv */
module dnakm_queue import dnakm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = mem[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_cmd;
    end
  end

endmodule

/* rtl/core/dnakm_back.sv */
`include "assert_macros.svh"
module dnakm_back import dnakm_pkg::*; #(
  parameter int NUM_STATES = 65536,
  parameter int LIST_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        matched,
  output logic [15:0] match_group,
  output logic [15:0] state_after,
  output logic        last
);

  localparam int SAW    = $clog2(NUM_STATES);
  localparam int GDEPTH = NUM_STATES * 5;
  localparam int GAW    = $clog2(GDEPTH);
  localparam int LAW    = LIST_DEPTH > 1 ? $clog2(LIST_DEPTH) : 1;
  localparam int STEP_W = $clog2(NUM_STATES + 1);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_GCHK = 3'd1;
  localparam logic [2:0] B_FAIL = 3'd2;
  localparam logic [2:0] B_DESC = 3'd3;
  localparam logic [2:0] B_LIST = 3'd4;

  logic [2:0]        bstate;
  logic [15:0]       cur_state;
  logic [15:0]       s_r;
  logic              s_ok;
  logic [2:0]        sym_r;
  logic [STEP_W-1:0] steps;
  logic [15:0]       next_r;
  logic              n_ok;
  logic [3:0]        cnt_r;
  logic [3:0]        k_r;
  logic [LAW-1:0]    lidx;

  logic           g_we, g_re;
  logic [GAW-1:0] g_waddr, g_raddr;
  logic [16:0]    g_wdata, g_rdata;
  logic           f_we, f_re;
  logic [SAW-1:0] f_waddr, f_raddr;
  logic [35:0]    f_wdata, f_rdata;
  logic           l_we, l_re;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [15:0]    l_wdata, l_rdata;

  logic           pop, out_free, g_hit, walk_done, fail_ok, cur_ok, k_last, emit;
  logic [15:0]    next_val, fail_s, d_start;
  logic [3:0]     d_cnt;
  logic [LAW-1:0] lidx_inc;

  function automatic logic [GAW-1:0] goto_addr(input logic [15:0] s, input logic [2:0] c);
    return (GAW'(s) << 2) + GAW'(s) + GAW'(c);
  endfunction

  dnakm_ram #(.WIDTH(17), .DEPTH(GDEPTH)) u_goto (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .re(g_re), .raddr(g_raddr), .rdata(g_rdata)
  );
  dnakm_ram #(.WIDTH(36), .DEPTH(NUM_STATES)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
  );
  dnakm_ram #(.WIDTH(16), .DEPTH(LIST_DEPTH)) u_list (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );

  assign cmd_ready = bstate == B_IDLE;
  assign pop       = cmd_valid && cmd_ready;
  assign out_free  = !result_valid || result_ready;

  // Table loads
  assign g_we    = pop && (cmd.op == OP_LOAD_GOTO);
  assign g_waddr = goto_addr(cmd.index, cmd.sym);
  assign g_wdata = {cmd.tvalid, cmd.target};
  assign f_we    = pop && (cmd.op == OP_LOAD_FAIL);
  assign f_waddr = SAW'(cmd.index);
  assign f_wdata = {cmd.count, cmd.start, cmd.target};
  assign l_we    = pop && (cmd.op == OP_LOAD_LIST);
  assign l_waddr = LAW'(cmd.index);
  assign l_wdata = cmd.target;

  // Walk decode; states beyond the table read as empty
  assign cur_ok    = 32'(cur_state) < NUM_STATES;
  assign g_hit     = g_rdata[16] && s_ok;
  assign walk_done = (s_r == 16'd0) || g_hit || (32'(steps) == NUM_STATES);
  assign next_val  = g_hit ? g_rdata[15:0] : 16'd0;
  assign fail_s    = s_ok ? f_rdata[15:0] : 16'd0;
  assign fail_ok   = 32'(fail_s) < NUM_STATES;
  assign d_start   = f_rdata[31:16];
  assign d_cnt     = n_ok ? f_rdata[35:32] : 4'd0;
  assign k_last    = (k_r + 4'd1) == cnt_r;
  assign lidx_inc  = (32'(lidx) == LIST_DEPTH - 1) ? '0 : lidx + 1'b1;

  // Load the result register this cycle
  assign emit = out_free &&
                (((bstate == B_DESC) && (d_cnt == 4'd0)) || (bstate == B_LIST));

  // Read port control
  always_comb begin
    g_re    = 1'b0;
    g_raddr = goto_addr(fail_s, sym_r);
    f_re    = 1'b0;
    f_raddr = SAW'(next_val);
    l_re    = 1'b0;
    l_raddr = lidx_inc;
    unique case (bstate)
      B_IDLE: begin
        g_re    = pop && (cmd.op == OP_BASE);
        g_raddr = goto_addr(cur_state, cmd.sym);
      end
      B_GCHK: begin
        f_re    = 1'b1;
        f_raddr = walk_done ? SAW'(next_val) : SAW'(s_r);
      end
      B_FAIL: begin
        g_re = 1'b1;
      end
      B_DESC: begin
        l_re    = out_free && (d_cnt != 4'd0);
        l_raddr = LAW'(d_start);
      end
      B_LIST: begin
        l_re = out_free && !k_last;
      end
      default: begin
        g_re = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate       <= B_IDLE;
      cur_state    <= 16'd0;
      result_valid <= 1'b0;
    end else begin
      if (emit) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
      unique case (bstate)
        B_IDLE: begin
          if (pop && cmd.op == OP_BASE) bstate <= B_GCHK;
          if (pop && cmd.op == OP_READ_START) cur_state <= 16'd0;
        end
        B_GCHK: begin
          if (walk_done) begin
            cur_state <= next_val;
            bstate    <= B_DESC;
          end else begin
            bstate <= B_FAIL;
          end
        end
        B_FAIL: bstate <= B_GCHK;
        B_DESC: begin
          if (out_free) begin
            if (d_cnt == 4'd0) begin
              bstate <= B_IDLE;
            end else begin
              bstate <= B_LIST;
            end
          end
        end
        B_LIST: begin
          if (out_free && k_last) bstate <= B_IDLE;
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

  // Walk and emission payload
  always_ff @(posedge clk) begin
    unique case (bstate)
      B_IDLE: begin
        s_r   <= cur_state;
        s_ok  <= cur_ok;
        sym_r <= cmd.sym;
        steps <= '0;
      end
      B_GCHK: begin
        next_r <= next_val;
        n_ok   <= 32'(next_val) < NUM_STATES;
      end
      B_FAIL: begin
        s_r   <= fail_s;
        s_ok  <= fail_ok;
        steps <= steps + 1'b1;
      end
      B_DESC: begin
        cnt_r <= d_cnt;
        k_r   <= 4'd0;
        lidx  <= LAW'(d_start);
        if (out_free) begin
          matched     <= 1'b0;
          match_group <= 16'd0;
          state_after <= next_r;
          last        <= 1'b1;
        end
      end
      B_LIST: begin
        if (out_free) begin
          matched     <= 1'b1;
          match_group <= l_rdata;
          state_after <= next_r;
          last        <= k_last;
          k_r         <= k_r + 4'd1;
          lidx        <= lidx_inc;
        end
      end
      default: begin
        steps <= '0;
      end
    endcase
  end

  `DNAKM_ASSERT_NEVER(a_k_bound, clk, rst, (bstate == B_LIST) && (k_r >= cnt_r), "list index past count")
  `DNAKM_ASSERT(a_nomatch_last, clk, rst, result_valid && !matched |-> last && (match_group == 16'd0), "bad no-match result")
  `DNAKM_ASSERT_NEVER(a_step_bound, clk, rst, 32'(steps) > NUM_STATES, "failure walk overran")

endmodule

/* bench/dna_multi_keyword_matcher_core_tb.sv */
`timescale 1ns / 100ps

module dna_multi_keyword_matcher_core_tb;
  import dnakm_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] state_index;
    logic [2:0]  symbol;
    logic [15:0] target_state;
    logic        target_valid;
    logic [15:0] out_start;
    logic [3:0]  out_count;
    logic [15:0] list_index;
    logic [15:0] group_id;
    logic [7:0]  base;
    bit          typed;      // expected result written by hand (single no-match)
    logic [15:0] typed_state;
  } item_t;

  typedef struct {
    logic        matched;
    logic [15:0] match_group;
    logic [15:0] state_after;
    logic        last;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid, item_ready, result_valid, result_ready;
  logic [2:0] op, symbol;
  logic [15:0] state_index, target_state, out_start, list_index, group_id;
  logic target_valid;
  logic [3:0] out_count;
  logic [7:0] base;
  logic matched, last;
  logic [15:0] match_group, state_after;

  dna_multi_keyword_matcher_core u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .op(op), .state_index(state_index), .symbol(symbol),
    .target_state(target_state), .target_valid(target_valid),
    .out_start(out_start), .out_count(out_count),
    .list_index(list_index), .group_id(group_id), .base(base),
    .result_valid(result_valid), .result_ready(result_ready),
    .matched(matched), .match_group(match_group),
    .state_after(state_after), .last(last)
  );

  always #2 clk = ~clk;

  // shadow automaton
  logic [16:0] goto_shadow [int];
  logic [15:0] fail_shadow [int];
  logic [19:0] desc_shadow [int];
  logic [15:0] group_shadow [int];
  logic [15:0] cur_state;

  match_t pending_matches [$];
  int errors = 0;
  int idle_cycles = 0;
  bit send_fast = 0;
  bit recv_fast = 0;
  int recv_stall = 0;
  item_t directed [$];

  function automatic logic [2:0] sym_of(logic [7:0] b);
    case (b)
      CHAR_A:  return SYM_A;
      CHAR_C:  return SYM_C;
      CHAR_G:  return SYM_G;
      CHAR_T:  return SYM_T;
      default: return SYM_OTHER;
    endcase
  endfunction

  function automatic logic [16:0] goto_of(logic [15:0] s, logic [2:0] c);
    int key;
    key = int'(s) * 5 + int'(c);
    return goto_shadow.exists(key) ? goto_shadow[key] : 17'd0;
  endfunction

  // Update the shadow tables and queue the matches one transaction causes
  task automatic track_item(item_t it);
    logic [15:0] s;
    logic [16:0] g;
    logic [19:0] d;
    logic [2:0] c;
    int cnt;
    int steps;
    int idx;
    match_t m;
    case (it.op)
      OP_LOAD_GOTO: begin
        if (it.symbol <= SYM_OTHER)
          goto_shadow[int'(it.state_index) * 5 + int'(it.symbol)] =
            {it.target_valid, it.target_state};
      end
      OP_LOAD_FAIL: begin
        fail_shadow[it.state_index] = it.target_state;
        desc_shadow[it.state_index] = {it.out_count, it.out_start};
      end
      OP_LOAD_LIST: group_shadow[it.list_index] = it.group_id;
      OP_READ_START: cur_state = 16'd0;
      OP_BASE: begin
        c = sym_of(it.base);
        s = cur_state;
        steps = 0;
        g = goto_of(s, c);
        while (s != 0 && !g[16] && steps < 65536) begin
          s = fail_shadow.exists(s) ? fail_shadow[s] : 16'd0;
          steps++;
          g = goto_of(s, c);
        end
        cur_state = g[16] ? g[15:0] : 16'd0;
        d = desc_shadow.exists(cur_state) ? desc_shadow[cur_state] : 20'd0;
        cnt = (d[19:16] > 8) ? 8 : int'(d[19:16]);
        if (it.typed) begin
          m = '{1'b0, 16'd0, it.typed_state, 1'b1};
          pending_matches.insert(pending_matches.size(), m);
        end else if (cnt == 0) begin
          m = '{1'b0, 16'd0, cur_state, 1'b1};
          pending_matches.insert(pending_matches.size(), m);
        end else begin
          for (int k = 0; k < cnt; k++) begin
            idx = (int'(d[15:0]) + k) % 65536;
            m.matched = 1'b1;
            m.match_group = group_shadow.exists(idx) ? group_shadow[idx] : 16'd0;
            m.state_after = cur_state;
            m.last = (k + 1 == cnt);
            pending_matches.insert(pending_matches.size(), m);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.op = 3'($urandom_range(5, 7));
    it.state_index = 16'($urandom);
    it.symbol = 3'($urandom);
    it.target_state = 16'($urandom);
    it.target_valid = 1'($urandom);
    it.out_start = 16'($urandom);
    it.out_count = 4'($urandom);
    it.list_index = 16'($urandom);
    it.group_id = 16'($urandom);
    it.base = 8'($urandom);
    it.typed = 0;
    it.typed_state = 16'd0;
    return it;
  endfunction

  function automatic item_t goto_item(logic [15:0] s, logic [2:0] c, logic [15:0] t,
                                      logic v);
    item_t it;
    it = rand_item();
    it.op = OP_LOAD_GOTO;
    it.state_index = s;
    it.symbol = c;
    it.target_state = t;
    it.target_valid = v;
    return it;
  endfunction

  function automatic item_t fail_item(logic [15:0] s, logic [15:0] f, logic [15:0] st,
                                      logic [3:0] cnt);
    item_t it;
    it = rand_item();
    it.op = OP_LOAD_FAIL;
    it.state_index = s;
    it.target_state = f;
    it.out_start = st;
    it.out_count = cnt;
    return it;
  endfunction

  function automatic item_t list_item(logic [15:0] i, logic [15:0] g);
    item_t it;
    it = rand_item();
    it.op = OP_LOAD_LIST;
    it.list_index = i;
    it.group_id = g;
    return it;
  endfunction

  function automatic item_t base_item(logic [7:0] b, bit typed, logic [15:0] ts);
    item_t it;
    it = rand_item();
    it.op = OP_BASE;
    it.base = b;
    it.typed = typed;
    it.typed_state = ts;
    return it;
  endfunction

  function automatic item_t restart_item();
    item_t it;
    it = rand_item();
    it.op = OP_READ_START;
    return it;
  endfunction

  // Append one row to the directed table
  task automatic add_row(item_t it);
    directed.insert(directed.size(), it);
  endtask

  // Drive one transaction, hold it until accepted, then predict
  task automatic send(item_t it);
    int gap;
    if ($urandom_range(0, 19) == 0) send_fast = ~send_fast;
    gap = send_fast ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= it.op;
    state_index <= it.state_index;
    symbol <= it.symbol;
    target_state <= it.target_state;
    target_valid <= it.target_valid;
    out_start <= it.out_start;
    out_count <= it.out_count;
    list_index <= it.list_index;
    group_id <= it.group_id;
    base <= it.base;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    track_item(it);
  endtask

  // Compare each accepted result with the oldest expectation; pace ready
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_matches.size() == 0) begin
          $error("unexpected result: group %0d state %0d", match_group, state_after);
          errors++;
        end else begin
          match_t m;
          m = pending_matches.pop_front();
          if (matched !== m.matched) begin
            $error("matched: expected %0d, got %0d", m.matched, matched);
            errors++;
          end
          if (match_group !== m.match_group) begin
            $error("match_group: expected %0d, got %0d", m.match_group, match_group);
            errors++;
          end
          if (state_after !== m.state_after) begin
            $error("state_after: expected %0d, got %0d", m.state_after, state_after);
            errors++;
          end
          if (last !== m.last) begin
            $error("last: expected %0d, got %0d", m.last, last);
            errors++;
          end
        end
        if ($urandom_range(0, 24) == 0) recv_fast = ~recv_fast;
        recv_stall = recv_fast ? 0 : $urandom_range(0, 18);
      end
      if (recv_stall > 0) begin
        result_ready <= 1'b0;
        recv_stall--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Build one small automaton with acyclic failure links, load it, then run a read
  task automatic run_phase(int nbases);
    logic [15:0] ids [8];
    int n;
    int cnt;
    logic [15:0] st;
    item_t it;
    n = $urandom_range(2, 7);
    ids[0] = 16'd0;
    // Distinct nonzero states, one per band
    for (int i = 1; i < n; i++) ids[i] = 16'(i * 9000 + $urandom_range(1, 8999));
    for (int i = 0; i < n; i++) begin
      for (int c = 0; c <= 4; c++)
        send(goto_item(ids[i], 3'(c), ids[$urandom_range(0, n - 1)],
                       ($urandom_range(0, 2) != 0)));
      st = ($urandom_range(0, 3) == 0) ? 16'(65535 - $urandom_range(0, 6)) : 16'($urandom);
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 4);
      send(fail_item(ids[i], (i == 0) ? 16'd0 : ids[$urandom_range(0, i - 1)], st, 4'(cnt)));
      for (int k = 0; k < ((cnt > 8) ? 8 : cnt); k++)
        send(list_item(16'((int'(st) + k) % 65536), 16'($urandom)));
    end
    send(restart_item());
    for (int b = 0; b < nbases; b++) begin
      case ($urandom_range(0, 29))
        0: send(restart_item());
        1: send(rand_item());
        2: send(goto_item(16'($urandom), 3'($urandom_range(5, 7)), 16'($urandom),
                          1'($urandom)));
        3, 4, 5: send(base_item(8'($urandom), 0, 16'd0));
        default: begin
          case ($urandom_range(0, 3))
            0: it = base_item(CHAR_A, 0, 16'd0);
            1: it = base_item(CHAR_C, 0, 16'd0);
            2: it = base_item(CHAR_G, 0, 16'd0);
            default: it = base_item(CHAR_T, 0, 16'd0);
          endcase
          send(it);
        end
      endcase
    end
  endtask

  initial begin
    item_valid <= 1'b0;
    op <= OP_READ_START;
    state_index <= '0;
    symbol <= '0;
    target_state <= '0;
    target_valid <= 1'b0;
    out_start <= '0;
    out_count <= '0;
    list_index <= '0;
    group_id <= '0;
    base <= '0;
    cur_state = 16'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Root: A goes to the top state, other symbols undefined, empty output set
    add_row(fail_item(16'd0, 16'd0, 16'd0, 4'd0));
    add_row(goto_item(16'd0, SYM_A, 16'hFFFF, 1'b1));
    add_row(goto_item(16'd0, SYM_C, 16'hFFFF, 1'b0));
    add_row(goto_item(16'd0, SYM_G, 16'h0000, 1'b0));
    add_row(goto_item(16'd0, SYM_T, 16'h5555, 1'b0));
    add_row(goto_item(16'd0, SYM_OTHER, 16'hAAAA, 1'b0));
    add_row(goto_item(16'd0, 3'd7, 16'hFFFF, 1'b1));
    // Top state: count above the cap, list start wrapping past the end
    add_row(fail_item(16'hFFFF, 16'd0, 16'hFFFE, 4'd15));
    for (int i = 0; i < 8; i++)
      add_row(list_item(16'(16'hFFFE + i), (i == 0) ? 16'hFFFF : 16'(i - 1)));
    for (int c = 0; c <= 4; c++)
      add_row(goto_item(16'hFFFF, 3'(c), 16'd0, 1'b0));
    add_row(rand_item());
    add_row(base_item(CHAR_A, 0, 16'd0));
    // Undefined at the top state falls back to the root, then undefined there too
    add_row(base_item(CHAR_C, 1, 16'd0));
    add_row(base_item(8'hFF, 1, 16'd0));
    add_row(base_item(CHAR_A, 0, 16'd0));
    add_row(restart_item());
    add_row(base_item(8'h00, 1, 16'd0));
    foreach (directed[i]) send(directed[i]);

    for (int p = 0; p < 2; p++) begin
      run_phase(25);
    end
    item_valid <= 1'b0;

    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* dna_multi_keyword_matcher_core.f */
+incdir+rtl/core
rtl/core/dnakm_pkg.sv
rtl/core/dnakm_ram.sv
rtl/core/dnakm_front.sv
rtl/core/dnakm_queue.sv
rtl/core/dnakm_back.sv
rtl/core/dna_multi_keyword_matcher_core.sv
bench/dna_multi_keyword_matcher_core_tb.sv
